// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the filter unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every clock edge outside reset
`define BQ_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that prop holds in the cycle after trig
`define BQ_ASSERT_NEXT(name, clk, rst, trig, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

// File: rtl/core/bqtdf_pkg.sv
// ---------------------------------------------------------------------------
// Biquad filter package
// Register indexes, coefficient set and datapath command types.
// ---------------------------------------------------------------------------
package bqtdf_pkg;

  localparam int COEF_BITS      = 24;
  localparam int CFG_DATA_BITS  = 24;
  localparam int REG_INDEX_BITS = 3;

  localparam logic [REG_INDEX_BITS-1:0] REG_ENABLE = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_B0     = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_B1     = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_B2     = 3'd3;
  localparam logic [REG_INDEX_BITS-1:0] REG_A1     = 3'd4;
  localparam logic [REG_INDEX_BITS-1:0] REG_A2     = 3'd5;

  localparam logic signed [COEF_BITS-1:0] B0_RESET = 24'sd4194304;

  typedef struct packed {
    logic                        enable;
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coef_set_t;

  typedef enum logic [2:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_SUB  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,
    FIN_Y    = 2'd1,
    FIN_D1   = 2'd2,
    FIN_D2   = 2'd3
  } fin_op_t;

  typedef struct packed {
    logic      load_in;
    logic      mul_en;
    coef_sel_t coef_sel;
    logic      mul_y;
    acc_op_t   acc_op;
    fin_op_t   fin_op;
    logic      out_load;
  } dp_cmd_t;

endpackage

// File: rtl/core/bqtdf_ifs.sv
// ---------------------------------------------------------------------------
// Biquad filter channels
// Valid/ready sample channels for the filter input and output.
// ---------------------------------------------------------------------------
interface bqtdf_in_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          block_end_in;

  modport source (output valid, sample_in, block_end_in, input ready);
  modport sink   (input valid, sample_in, block_end_in, output ready);
endinterface

interface bqtdf_out_if #(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          block_end_out;

  modport source (output valid, sample_out, block_end_out, input ready);
  modport sink   (input valid, sample_out, block_end_out, output ready);
endinterface

// File: rtl/core/bqtdf_regs.sv
// ---------------------------------------------------------------------------
// Biquad filter configuration registers
// Enable flag and five coefficient registers behind a plain write port.
// ---------------------------------------------------------------------------
module bqtdf_regs (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wr_en,
  input  logic [bqtdf_pkg::REG_INDEX_BITS-1:0]  wr_index,
  input  logic [bqtdf_pkg::CFG_DATA_BITS-1:0]   wr_data,
  output bqtdf_pkg::coef_set_t                   cfg
);
  import bqtdf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.b0     <= B0_RESET;
      cfg.b1     <= '0;
      cfg.b2     <= '0;
      cfg.a1     <= '0;
      cfg.a2     <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ENABLE: cfg.enable <= wr_data[0];
        REG_B0:     cfg.b0     <= COEF_BITS'(wr_data);
        REG_B1:     cfg.b1     <= COEF_BITS'(wr_data);
        REG_B2:     cfg.b2     <= COEF_BITS'(wr_data);
        REG_A1:     cfg.a1     <= COEF_BITS'(wr_data);
        REG_A2:     cfg.a2     <= COEF_BITS'(wr_data);
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/bqtdf_datapath.sv
// ---------------------------------------------------------------------------
// Biquad filter datapath
// Shared multiplier, accumulator, rounding, saturation and delay state.
// ---------------------------------------------------------------------------
module bqtdf_datapath #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 22,
  parameter int STATE_BITS     = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bqtdf_pkg::dp_cmd_t            cmd,
  input  bqtdf_pkg::coef_set_t          cfg,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          block_end_in,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          block_end_out
);
  import bqtdf_pkg::*;

  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RND_W  = ACC_W - COEF_FRAC_BITS;
  localparam int SUM_W  = ((RND_W > STATE_BITS) ? RND_W : STATE_BITS) + 1;

  localparam logic signed [ACC_W-1:0] HALF =
    ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0] ST_MAX =
    SUM_W'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [SUM_W-1:0] SMP_MAX =
    SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SMP_MIN = ~SMP_MAX;

  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] y;
  logic                          blk;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [STATE_BITS-1:0]  delay_one;
  logic signed [STATE_BITS-1:0]  delay_two;

  logic signed [COEF_BITS-1:0]   coef;
  logic signed [SAMPLE_BITS-1:0] operand;
  logic signed [RND_W-1:0]       rnd;
  logic signed [STATE_BITS-1:0]  addend;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       sum_st;
  logic signed [SUM_W-1:0]       sum_smp;

  always_comb begin
    case (cmd.coef_sel)
      COEF_B0: coef = cfg.b0;
      COEF_B1: coef = cfg.b1;
      COEF_B2: coef = cfg.b2;
      COEF_A1: coef = cfg.a1;
      COEF_A2: coef = cfg.a2;
      default: coef = cfg.b0;
    endcase
    operand = cmd.mul_y ? y : x;
  end

  always_comb begin
    case (cmd.fin_op)
      FIN_Y:   addend = delay_one;
      FIN_D1:  addend = delay_two;
      default: addend = '0;
    endcase
    rnd     = RND_W'(acc >>> COEF_FRAC_BITS);
    sum     = SUM_W'(rnd) + SUM_W'(addend);
    sum_st  = (sum > ST_MAX) ? ST_MAX : ((sum < ST_MIN) ? ST_MIN : sum);
    sum_smp = (sum > SMP_MAX) ? SMP_MAX : ((sum < SMP_MIN) ? SMP_MIN : sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x   <= sample_in;
      y   <= sample_in;
      blk <= block_end_in;
    end else if (cmd.fin_op == FIN_Y) begin
      y <= SAMPLE_BITS'(sum_smp);
    end
    if (cmd.mul_en) begin
      prod <= coef * operand;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc <= ACC_W'(prod) + HALF;
      ACC_SUB:  acc <= acc - ACC_W'(prod);
      default: ;
    endcase
    if (cmd.out_load) begin
      sample_out    <= y;
      block_end_out <= blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      case (cmd.fin_op)
        FIN_D1:  delay_one <= STATE_BITS'(sum_st);
        FIN_D2:  delay_two <= STATE_BITS'(sum_st);
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/bqtdf_ctrl.sv
// ---------------------------------------------------------------------------
// Biquad filter controller
// Sequences the five multiplies, the state updates and the output hand-off.
// ---------------------------------------------------------------------------
module bqtdf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_ready,
  input  logic               enable,
  output logic               in_ready,
  output logic               out_valid,
  output bqtdf_pkg::dp_cmd_t cmd
);
  import bqtdf_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_MB0  = 13'b0000000000010,
    S_LB0  = 13'b0000000000100,
    S_FY   = 13'b0000000001000,
    S_MB1  = 13'b0000000010000,
    S_LB1  = 13'b0000000100000,
    S_SA1  = 13'b0000001000000,
    S_FN1  = 13'b0000010000000,
    S_MB2  = 13'b0000100000000,
    S_LB2  = 13'b0001000000000,
    S_SA2  = 13'b0010000000000,
    S_FN2  = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.coef_sel = COEF_B0;
    cmd.acc_op = ACC_HOLD;
    cmd.fin_op = FIN_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = enable ? S_MB0 : S_OUT;
        end
      end
      S_MB0: begin
        cmd.mul_en = 1'b1;
        state_next = S_LB0;
      end
      S_LB0: begin
        cmd.acc_op = ACC_LOAD;
        state_next = S_FY;
      end
      S_FY: begin
        cmd.fin_op = FIN_Y;
        state_next = S_MB1;
      end
      S_MB1: begin
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_B1;
        state_next   = S_LB1;
      end
      S_LB1: begin
        cmd.acc_op   = ACC_LOAD;
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_A1;
        cmd.mul_y    = 1'b1;
        state_next   = S_SA1;
      end
      S_SA1: begin
        cmd.acc_op = ACC_SUB;
        state_next = S_FN1;
      end
      S_FN1: begin
        cmd.fin_op = FIN_D1;
        state_next = S_MB2;
      end
      S_MB2: begin
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_B2;
        state_next   = S_LB2;
      end
      S_LB2: begin
        cmd.acc_op   = ACC_LOAD;
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_A2;
        cmd.mul_y    = 1'b1;
        state_next   = S_SA2;
      end
      S_SA2: begin
        cmd.acc_op = ACC_SUB;
        state_next = S_FN2;
      end
      S_FN2: begin
        cmd.fin_op = FIN_D2;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/biquad_tdf2_filter_unit.sv
// ---------------------------------------------------------------------------
// Biquad filter unit
// Second-order IIR section, transposed direct form II, one shared multiplier.
// ---------------------------------------------------------------------------
//  Channel   Kind         Payload
//  audio     valid/ready  sample_in, block_end_in
//  filtered  valid/ready  sample_out, block_end_out
//  wr_*      write only   wr_index, wr_data
//
//  A filtered request runs five multiplies through one coefficient x sample
//  multiplier, with accumulate steps and three round/saturate steps for y and
//  the delay state. A bypassed request skips them and goes to the output step.
//  Reset clears the delay state and loads the coefficient reset values.
//  The output register holds a result while the sink stalls; a new request
//  is accepted meanwhile and waits in its final step until the register frees.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module biquad_tdf2_filter_unit #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 22,
  parameter int STATE_BITS     = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [bqtdf_pkg::REG_INDEX_BITS-1:0] wr_index,
  input  logic [bqtdf_pkg::CFG_DATA_BITS-1:0]  wr_data,
  bqtdf_in_if.sink                              audio,
  bqtdf_out_if.source                           filtered
);
  import bqtdf_pkg::*;

  coef_set_t cfg;
  dp_cmd_t   cmd;

  bqtdf_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  bqtdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (audio.valid),
    .out_ready (filtered.ready),
    .enable    (cfg.enable),
    .in_ready  (audio.ready),
    .out_valid (filtered.valid),
    .cmd       (cmd)
  );

  bqtdf_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .STATE_BITS     (STATE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .sample_in     (audio.sample_in),
    .block_end_in  (audio.block_end_in),
    .sample_out    (filtered.sample_out),
    .block_end_out (filtered.block_end_out)
  );

  `BQ_ASSERT(a_no_overwrite, clk, rst, !cmd.out_load || !filtered.valid || filtered.ready, "output overwritten while stalled")
  `BQ_ASSERT_NEXT(a_one_request, clk, rst, audio.valid && audio.ready, !audio.ready, "second request accepted while busy")
  `BQ_ASSERT(a_state_when_enabled, clk, rst, (cmd.fin_op == FIN_NONE) || cfg.enable, "state updated while bypassed")

endmodule

// File: sim/biquad_tdf2_filter_unit_tb.sv
// ---------------------------------------------------------------------------
// Biquad filter unit testbench
// Drives audio samples and coefficient writes into the filter unit. A
// fixed-point copy of the filter section predicts every filtered request;
// each output request is checked field by field against the oldest
// prediction. A directed table covers bypass, rounding, saturation and
// register decode, then random phases mix coefficient sets and idle gaps.
// ---------------------------------------------------------------------------
module biquad_tdf2_filter_unit_tb;
  import bqtdf_pkg::*;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 22;
  localparam int STATE_BITS     = 32;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int IDLE_PAUSE     = 4;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [REG_INDEX_BITS-1:0] REG_UNUSED_LO = REG_A2 + 1'b1;
  localparam logic [REG_INDEX_BITS-1:0] REG_UNUSED_HI = '1;
  localparam logic [CFG_DATA_BITS-1:0]  WORD_MAX      = 24'h7F_FFFF;
  localparam logic [CFG_DATA_BITS-1:0]  WORD_MIN      = 24'h80_0000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;

  typedef struct packed {
    sample_t sample;
    logic    block_end;
  } audio_word_t;

  typedef enum logic [1:0] {
    DIR_WRITE,
    DIR_SAMPLE,
    DIR_SAMPLE_KNOWN
  } dir_kind_t;

  typedef struct packed {
    dir_kind_t                 kind;
    logic [REG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  value;
    logic                      block_end;
    sample_t                   known_out;
  } dir_step_t;

  typedef enum int {
    COEF_GENTLE,
    COEF_RANDOM,
    COEF_EXTREME,
    COEF_RESONANT
  } coef_style_t;

  localparam int DIR_STEPS = 37;
  localparam dir_step_t DIRECTED [DIR_STEPS] = '{
    '{DIR_SAMPLE_KNOWN, '0,            WORD_MAX,     1'b0, WORD_MAX},
    '{DIR_SAMPLE_KNOWN, '0,            WORD_MIN,     1'b0, WORD_MIN},
    '{DIR_SAMPLE_KNOWN, '0,            24'h00_0000,  1'b1, 24'h00_0000},
    '{DIR_SAMPLE_KNOWN, '0,            24'hFF_FFFF,  1'b0, 24'hFF_FFFF},
    '{DIR_WRITE,        REG_ENABLE,    24'h00_0001,  1'b0, '0},
    '{DIR_SAMPLE_KNOWN, '0,            WORD_MAX,     1'b0, WORD_MAX},
    '{DIR_SAMPLE_KNOWN, '0,            WORD_MIN,     1'b1, WORD_MIN},
    '{DIR_WRITE,        REG_B0,        24'h00_0001,  1'b0, '0},
    '{DIR_SAMPLE_KNOWN, '0,            24'h20_0000,  1'b0, 24'h00_0001},
    '{DIR_SAMPLE_KNOWN, '0,            24'hE0_0000,  1'b0, 24'h00_0000},
    '{DIR_SAMPLE_KNOWN, '0,            24'hDF_FFFF,  1'b0, 24'hFF_FFFF},
    '{DIR_WRITE,        REG_B0,        WORD_MAX,     1'b0, '0},
    '{DIR_SAMPLE_KNOWN, '0,            WORD_MAX,     1'b0, WORD_MAX},
    '{DIR_SAMPLE_KNOWN, '0,            WORD_MIN,     1'b0, WORD_MIN},
    '{DIR_WRITE,        REG_B0,        WORD_MIN,     1'b0, '0},
    '{DIR_SAMPLE_KNOWN, '0,            WORD_MIN,     1'b0, WORD_MAX},
    '{DIR_SAMPLE_KNOWN, '0,            WORD_MAX,     1'b0, WORD_MIN},
    '{DIR_WRITE,        REG_B0,        B0_RESET,     1'b0, '0},
    '{DIR_WRITE,        REG_B1,        WORD_MAX,     1'b0, '0},
    '{DIR_WRITE,        REG_B2,        WORD_MIN,     1'b0, '0},
    '{DIR_WRITE,        REG_A1,        WORD_MIN,     1'b0, '0},
    '{DIR_WRITE,        REG_A2,        WORD_MAX,     1'b0, '0},
    '{DIR_SAMPLE,       '0,            WORD_MAX,     1'b0, '0},
    '{DIR_SAMPLE,       '0,            WORD_MIN,     1'b0, '0},
    '{DIR_SAMPLE,       '0,            WORD_MAX,     1'b1, '0},
    '{DIR_SAMPLE,       '0,            24'h00_0000,  1'b0, '0},
    '{DIR_SAMPLE,       '0,            24'h00_0000,  1'b0, '0},
    '{DIR_SAMPLE,       '0,            24'hFF_FFFF,  1'b1, '0},
    '{DIR_WRITE,        REG_UNUSED_LO, 24'h12_3456,  1'b0, '0},
    '{DIR_WRITE,        REG_UNUSED_HI, 24'hFF_FFFF,  1'b0, '0},
    '{DIR_WRITE,        REG_ENABLE,    24'hFF_FFFE,  1'b0, '0},
    '{DIR_SAMPLE_KNOWN, '0,            24'h00_3039,  1'b0, 24'h00_3039},
    '{DIR_SAMPLE_KNOWN, '0,            24'h80_FF00,  1'b1, 24'h80_FF00},
    '{DIR_WRITE,        REG_ENABLE,    24'h00_0001,  1'b0, '0},
    '{DIR_SAMPLE,       '0,            24'h00_0000,  1'b1, '0},
    '{DIR_SAMPLE,       '0,            24'h00_0001,  1'b0, '0},
    '{DIR_SAMPLE,       '0,            24'h7F_FF00,  1'b0, '0}
  };

  logic                      clk;
  logic                      rst;
  logic                      wr_en;
  logic [REG_INDEX_BITS-1:0] wr_index;
  logic [CFG_DATA_BITS-1:0]  wr_data;

  bqtdf_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) audio_if ();
  bqtdf_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) filtered_if ();

  biquad_tdf2_filter_unit #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .STATE_BITS     (STATE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .audio    (audio_if),
    .filtered (filtered_if)
  );

  coef_set_t   coef_model;
  state_t      delay_one;
  state_t      delay_two;
  audio_word_t pending_filtered [$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit          src_idle_on;
  bit          sink_stall_on;

  function automatic longint clamp(longint v, int bits);
    longint hi = (longint'(1) <<< (bits - 1)) - 1;
    longint lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round half up, then drop the coefficient fraction
  function automatic longint round_coef(longint acc);
    return (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
  endfunction

  function automatic sample_t filter_sample(sample_t x);
    longint xv;
    longint y_state;
    longint y_out;
    longint next_one;
    longint next_two;
    if (!coef_model.enable) return x;
    xv       = x;
    y_state  = clamp(round_coef(longint'(coef_model.b0) * xv) + longint'(delay_one),
                     STATE_BITS);
    y_out    = clamp(y_state, SAMPLE_BITS);
    next_one = clamp(round_coef(longint'(coef_model.b1) * xv
                                - longint'(coef_model.a1) * y_out) + longint'(delay_two),
                     STATE_BITS);
    next_two = clamp(round_coef(longint'(coef_model.b2) * xv
                                - longint'(coef_model.a2) * y_out), STATE_BITS);
    delay_one = state_t'(next_one);
    delay_two = state_t'(next_two);
    return sample_t'(y_out);
  endfunction

  function automatic void apply_reg(logic [REG_INDEX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_ENABLE: coef_model.enable = data[0];
      REG_B0:     coef_model.b0 = data;
      REG_B1:     coef_model.b1 = data;
      REG_B2:     coef_model.b2 = data;
      REG_A1:     coef_model.a1 = data;
      REG_A2:     coef_model.a2 = data;
      default: ;
    endcase
  endfunction

  function automatic int unsigned source_gap();
    int unsigned r;
    if (!src_idle_on) return 0;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 15) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned stall_len();
    if ($urandom_range(0, 15) < 15) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2, 3, 4: return sample_t'($urandom_range(0, 1024)) - sample_t'(512);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_coef(coef_style_t style);
    case (style)
      COEF_RANDOM: return CFG_DATA_BITS'($urandom);
      COEF_EXTREME: begin
        case ($urandom_range(0, 6))
          0:       return WORD_MAX;
          1:       return WORD_MIN;
          2:       return '0;
          3:       return 24'h00_0001;
          4:       return '1;
          5:       return B0_RESET;
          default: return -B0_RESET;
        endcase
      end
      default: return CFG_DATA_BITS'($urandom_range(0, 1 << 22) - (1 << 21));
    endcase
  endfunction

  task automatic send_sample(sample_t x, logic blk, bit known, sample_t known_out);
    audio_word_t want;
    @(negedge clk);
    audio_if.valid        <= 1'b1;
    audio_if.sample_in    <= x;
    audio_if.block_end_in <= blk;
    do @(posedge clk); while (!audio_if.ready);
    want.sample    = filter_sample(x);
    want.block_end = blk;
    if (known) want.sample = known_out;
    pending_filtered.push_back(want);
  endtask

  task automatic hold_source(int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk);
      audio_if.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    hold_source(1);
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic run_random_phase(int unsigned items);
    coef_style_t              style;
    logic [CFG_DATA_BITS-1:0] en_word;
    style         = coef_style_t'($urandom_range(0, 3));
    src_idle_on   = ($urandom_range(0, 3) != 0);
    sink_stall_on = ($urandom_range(0, 3) != 0);
    settle();
    en_word    = CFG_DATA_BITS'($urandom);
    en_word[0] = ($urandom_range(0, 7) != 0);
    write_reg(REG_ENABLE, en_word);
    if ($urandom_range(0, 7) != 0) write_reg(REG_B0, pick_coef(style));
    if ($urandom_range(0, 7) != 0) write_reg(REG_B1, pick_coef(style));
    if ($urandom_range(0, 7) != 0) write_reg(REG_B2, pick_coef(style));
    if (style == COEF_RESONANT) begin
      write_reg(REG_A1, CFG_DATA_BITS'($urandom_range(0, (1 << 24) - (1 << 19))
                                       - ((1 << 23) - (1 << 18))));
      write_reg(REG_A2, B0_RESET - CFG_DATA_BITS'($urandom_range(1, 1 << 16)));
    end else begin
      if ($urandom_range(0, 7) != 0) write_reg(REG_A1, pick_coef(style));
      if ($urandom_range(0, 7) != 0) write_reg(REG_A2, pick_coef(style));
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                CFG_DATA_BITS'($urandom));
    end
    repeat (items) begin
      send_sample(random_sample(), ($urandom_range(0, 7) == 0), 1'b0, '0);
      hold_source(source_gap());
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    filtered_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_stall_on && $urandom_range(0, 3) == 0) begin
        filtered_if.ready <= 1'b0;
        repeat (stall_len() - 1) @(negedge clk);
      end else begin
        filtered_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    audio_word_t want;
    if (!rst && filtered_if.valid && filtered_if.ready) begin
      if (pending_filtered.size() == 0) begin
        $error("sample_out: expected none, actual %0d", filtered_if.sample_out);
        mismatch_count++;
      end else begin
        want = pending_filtered.pop_front();
        if (filtered_if.sample_out !== want.sample) begin
          $error("sample_out: expected %0d, actual %0d", want.sample, filtered_if.sample_out);
          mismatch_count++;
        end
        if (filtered_if.block_end_out !== want.block_end) begin
          $error("block_end_out: expected %0d, actual %0d", want.block_end,
                 filtered_if.block_end_out);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (audio_if.valid && audio_if.ready) ||
        (filtered_if.valid && filtered_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** biquad_tdf2_filter_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase_items;
    dir_step_t   step;
    rst                   = 1'b1;
    wr_en                 = 1'b0;
    wr_index              = '0;
    wr_data               = '0;
    audio_if.valid        = 1'b0;
    audio_if.sample_in    = '0;
    audio_if.block_end_in = 1'b0;
    mismatch_count        = 0;
    quiet_cycles          = 0;
    src_idle_on           = 1'b1;
    sink_stall_on         = 1'b1;
    coef_model            = '{enable: 1'b0, b0: B0_RESET, default: '0};
    delay_one             = '0;
    delay_two             = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_STEPS; i++) begin
      step = DIRECTED[i];
      case (step.kind)
        DIR_WRITE: begin
          settle();
          write_reg(step.index, step.value);
        end
        DIR_SAMPLE: begin
          send_sample(step.value, step.block_end, 1'b0, '0);
          hold_source(source_gap());
        end
        default: begin
          send_sample(step.value, step.block_end, 1'b1, step.known_out);
          hold_source(source_gap());
        end
      endcase
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_items = $urandom_range(40, 120);
      run_random_phase(phase_items);
      sent += phase_items;
    end

    hold_source(1);
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** biquad_tdf2_filter_unit: PASSED **");
    end else begin
      $display("** biquad_tdf2_filter_unit: FAILED **");
    end
    $finish;
  end

endmodule
